FILE: design/ept_four_level_walker_defines.svh
// Assertion macros for the extended page table walker.
// Included by design files that carry concurrent checks; no other dependencies.
`ifndef EPT_FOUR_LEVEL_WALKER_DEFINES_SVH
`define EPT_FOUR_LEVEL_WALKER_DEFINES_SVH
`ifndef SYNTHESIS
`define EPT_ASSERT_IMPLIES(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("ept walker check failed: same-cycle implication");
`define EPT_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("ept walker check failed: next-cycle implication");
`else
`define EPT_ASSERT_IMPLIES(label, clk, rst, cond, expr)
`define EPT_ASSERT_NEXT(label, clk, rst, cond, expr)
`endif
`endif

FILE: design/ept_pkg.sv
// Package for the extended page table walker: sizes, codes, item structs, states.
// No dependencies.
package ept_pkg;

   localparam int TABLE_WORDS = 4096;
   localparam int TABLE_ENTRIES = 512;
   localparam int TABLE_PAGES = TABLE_WORDS / TABLE_ENTRIES;
   localparam int TABLE_ADDR_W = $clog2(TABLE_WORDS);

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_XLATE = 1'b1;

   localparam logic [1:0] PAGE_4K = 2'd0;
   localparam logic [1:0] PAGE_2M = 2'd1;
   localparam logic [1:0] PAGE_1G = 2'd2;

   localparam logic [1:0] LVL_PML4 = 2'd0;
   localparam logic [1:0] LVL_PDPT = 2'd1;
   localparam logic [1:0] LVL_PD   = 2'd2;
   localparam logic [1:0] LVL_PT   = 2'd3;

   typedef struct packed {
      logic        operation;
      logic [47:0] guest_addr;
      logic [11:0] table_word_index;
      logic [51:0] table_word_data;
   } req_type;

   typedef struct packed {
      logic [51:0] host_addr;
      logic        fault;
      logic [1:0]  page_size;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_EVAL
   } walk_state_type;

endpackage

FILE: design/ept_four_level_walker.sv
// Extended page table walker top level: table memory, clear pass and walk sequencer.
// Depends on ept_pkg and ept_four_level_walker_defines.svh.
//
//   channel  handshake              payload
//   req      start / busy           req_data  (ept_pkg::req_type)
//   rsp      rsp_valid (strobe)     rsp_data  (ept_pkg::rsp_type)
//   csr      csr_valid / csr_ready  csr_wdata (root table address)
//
// A write item leaves busy low. A translate item keeps busy high while the walk runs: the
// sequencer checks the root and issues the first read, then evaluates each entry read,
// paced by the single read port of the table memory and its registered read; the result
// strobe shows in the first cycle with busy low again. After reset a clear pass zeroes the
// table memory, one word a cycle, all TABLE_WORDS (4096) words, with busy high; csr writes
// are taken anytime. The receiver cannot stall.
`include "ept_four_level_walker_defines.svh"

module ept_four_level_walker (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  ept_pkg::req_type     req_data,
   output logic                 rsp_valid,
   output ept_pkg::rsp_type     rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [51:0]          csr_wdata
);
   import ept_pkg::*;

   walk_state_type state_ff, state_in;
   logic [1:0]              level_ff, level_in;
   logic [47:0]             ga_ff, ga_in;
   logic [51:0]             root_ff, root_in;
   logic [TABLE_ADDR_W-1:0] clr_addr_ff, clr_addr_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_ff, rsp_in;
   logic [51:0]             rd_data_ff;

   logic [51:0]             mem [TABLE_WORDS];

   logic                    mem_we;
   logic [TABLE_ADDR_W-1:0] mem_waddr;
   logic [51:0]             mem_wdata;
   logic                    mem_re;
   logic [TABLE_ADDR_W-1:0] mem_raddr;
   logic                    fin;
   rsp_type                 fin_data;

   logic                    accept;
   logic [31:0]             widx_wide;
   logic                    widx_ok;
   logic [39:0]             walk_page;
   logic [1:0]              walk_level;
   logic [48:0]             raddr_wide;
   logic                    entry_valid;
   logic                    entry_large;

   function automatic logic [8:0] level_index(input logic [1:0] lvl, input logic [47:0] ga);
      logic [8:0] idx;
      unique case (lvl)
         LVL_PML4: idx = ga[47:39];
         LVL_PDPT: idx = ga[38:30];
         LVL_PD:   idx = ga[29:21];
         LVL_PT:   idx = ga[20:12];
         default:  idx = ga[20:12];
      endcase
      return idx;
   endfunction

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign widx_wide = 32'(req_data.table_word_index);
   assign widx_ok   = (widx_wide < 32'(TABLE_WORDS));

   // page of the next table to read and the level it serves
   assign walk_page   = (state_ff == ST_LOOKUP) ? root_ff[51:12] : rd_data_ff[51:12];
   assign walk_level  = (state_ff == ST_LOOKUP) ? LVL_PML4 : level_ff + 2'd1;
   assign raddr_wide  = {walk_page, level_index(walk_level, ga_ff)};
   assign entry_valid = |rd_data_ff[2:0];
   assign entry_large = rd_data_ff[7];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_addr_ff == TABLE_ADDR_W'(TABLE_WORDS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start && req_data.operation == OP_XLATE) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP, ST_EVAL: begin
            state_in = mem_re ? ST_EVAL : ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer: memory ports and walk result
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = clr_addr_ff;
      mem_wdata = '0;
      mem_re    = 1'b0;
      mem_raddr = raddr_wide[TABLE_ADDR_W-1:0];
      fin       = 1'b0;
      fin_data  = '{host_addr: '0, fault: 1'b1, page_size: PAGE_4K};
      unique case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
         end
         ST_IDLE: begin
            if (start && req_data.operation == OP_WRITE && widx_ok) begin
               mem_we    = 1'b1;
               mem_waddr = widx_wide[TABLE_ADDR_W-1:0];
               mem_wdata = req_data.table_word_data;
            end
         end
         ST_LOOKUP: begin
            if (walk_page < 40'(TABLE_PAGES)) begin
               mem_re = 1'b1;
            end else begin
               fin = 1'b1;
            end
         end
         ST_EVAL: begin
            priority if (!entry_valid) begin
               fin = 1'b1;
            end else if (level_ff == LVL_PDPT && entry_large) begin
               fin      = 1'b1;
               fin_data = '{host_addr: {rd_data_ff[51:30], ga_ff[29:0]},
                            fault: 1'b0, page_size: PAGE_1G};
            end else if (level_ff == LVL_PD && entry_large) begin
               fin      = 1'b1;
               fin_data = '{host_addr: {rd_data_ff[51:21], ga_ff[20:0]},
                            fault: 1'b0, page_size: PAGE_2M};
            end else if (level_ff == LVL_PT) begin
               fin      = 1'b1;
               fin_data = '{host_addr: {rd_data_ff[51:12], ga_ff[11:0]},
                            fault: 1'b0, page_size: PAGE_4K};
            end else if (walk_page < 40'(TABLE_PAGES)) begin
               mem_re = 1'b1;
            end else begin
               fin = 1'b1;
            end
         end
         default: begin
            mem_re = 1'b0;
         end
      endcase
   end

   // datapath registers' next values
   always_comb begin
      ga_in        = ga_ff;
      level_in     = level_ff;
      clr_addr_in  = clr_addr_ff;
      root_in      = csr_valid ? csr_wdata : root_ff;
      rsp_valid_in = fin;
      rsp_in       = fin ? fin_data : rsp_ff;
      if (accept) begin
         ga_in    = req_data.guest_addr;
         level_in = LVL_PML4;
      end
      if (state_ff == ST_EVAL && mem_re) begin
         level_in = walk_level;
      end
      if (state_ff == ST_CLEAR) begin
         clr_addr_in = clr_addr_ff + TABLE_ADDR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         root_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         root_ff      <= root_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ga_ff    <= ga_in;
      level_ff <= level_in;
      rsp_ff   <= rsp_in;
   end

   // table memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         rd_data_ff <= mem[mem_raddr];
      end
   end

   `EPT_ASSERT_IMPLIES(a_fault_clean, clock, reset, rsp_valid_ff && rsp_ff.fault,
                       rsp_ff.host_addr == '0 && rsp_ff.page_size == PAGE_4K)
   `EPT_ASSERT_IMPLIES(a_size_legal, clock, reset, rsp_valid_ff, rsp_ff.page_size != 2'd3)
   `EPT_ASSERT_NEXT(a_strobe_single, clock, reset, rsp_valid_ff, !rsp_valid_ff)
   `EPT_ASSERT_NEXT(a_xlate_busy, clock, reset, accept && req_data.operation == OP_XLATE,
                    busy)

endmodule

FILE: tb/sv/ept_walk_checker.sv
// Checker for the extended page table walker: mirrors the table memory and root register,
// predicts each translation and compares it with the result strobe. Depends on ept_pkg.
module ept_walk_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             busy,
   input  ept_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  ept_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   input  logic             csr_ready,
   input  logic [51:0]      csr_wdata,
   output int               fail_count,
   output int               pending,
   output int               checked_count,
   output int               fault_count
);
   import ept_pkg::*;

   localparam int REPORT_LIMIT = 10;

   logic [51:0] table_image [TABLE_WORDS];
   logic [51:0] root_addr;
   rsp_type     expected_xlate_q [$];
   int          mismatches = 0;
   int          checked = 0;
   int          faults = 0;

   function automatic rsp_type walk_translate(logic [47:0] ga);
      rsp_type     res;
      logic [51:0] base;
      logic [51:0] ent;
      int          word;
      res = '0;
      res.fault = 1'b1;
      base = root_addr;
      for (int lvl = 0; lvl < 4; lvl++) begin
         // a table must lie wholly inside the memory
         if (base[51:12] >= TABLE_PAGES) return res;
         word = int'(base[51:12]) * TABLE_ENTRIES + int'(ga[47 - 9*lvl -: 9]);
         ent = table_image[word];
         if (ent[2:0] == 3'b000) return res;
         if (2'(lvl) == LVL_PDPT && ent[7]) begin
            res.host_addr = {ent[51:30], ga[29:0]};
            res.page_size = PAGE_1G;
            res.fault = 1'b0;
            return res;
         end
         if (2'(lvl) == LVL_PD && ent[7]) begin
            res.host_addr = {ent[51:21], ga[20:0]};
            res.page_size = PAGE_2M;
            res.fault = 1'b0;
            return res;
         end
         if (2'(lvl) == LVL_PT) begin
            res.host_addr = {ent[51:12], ga[11:0]};
            res.page_size = PAGE_4K;
            res.fault = 1'b0;
            return res;
         end
         base = ent;
      end
      return res;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int w = 0; w < TABLE_WORDS; w++) table_image[w] = '0;
         root_addr = '0;
         expected_xlate_q.delete();
      end else begin
         if (rsp_valid) begin
            if (expected_xlate_q.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("unexpected walk result: host=%h fault=%b size=%0d",
                           rsp_data.host_addr, rsp_data.fault, rsp_data.page_size);
            end else begin
               want = expected_xlate_q.pop_front();
               checked++;
               if (want.fault) faults++;
               if (rsp_data.host_addr !== want.host_addr || rsp_data.fault !== want.fault ||
                   rsp_data.page_size !== want.page_size) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT)
                     $display({"walk mismatch: expected host=%h fault=%b size=%0d, ",
                               "got host=%h fault=%b size=%0d"},
                              want.host_addr, want.fault, want.page_size,
                              rsp_data.host_addr, rsp_data.fault, rsp_data.page_size);
               end
            end
         end
         if (csr_valid && csr_ready) root_addr = csr_wdata;
         if (start && !busy) begin
            if (req_data.operation == OP_WRITE) begin
               if (req_data.table_word_index < TABLE_WORDS)
                  table_image[req_data.table_word_index] = req_data.table_word_data;
            end else begin
               expected_xlate_q.push_back(walk_translate(req_data.guest_addr));
            end
         end
      end
      fail_count <= mismatches;
      pending <= expected_xlate_q.size();
      checked_count <= checked;
      fault_count <= faults;
   end

endmodule

FILE: tb/sv/tb_ept_four_level_walker.sv
// Top of the extended page table walker testbench: clock, reset, table and walk stimulus,
// root register settings and verdict. Depends on ept_pkg, the walker and ept_walk_checker.
module tb_ept_four_level_walker;
   import ept_pkg::*;

   localparam int          HALF_PERIOD = 4;
   localparam int          RESET_CYCLES = 10;
   localparam int          DRAIN_CYCLES = 12;
   localparam int          CYCLE_LIMIT = 200000;
   localparam logic [51:0] ROOT_ALL_ONES = '1;

   logic        clock = 1'b0;
   logic        reset;
   logic        start;
   logic        busy;
   req_type     req_data;
   logic        rsp_valid;
   rsp_type     rsp_data;
   logic        csr_valid;
   logic        csr_ready;
   logic [51:0] csr_wdata;

   int fail_count;
   int pending;
   int checked_count;
   int fault_count;
   int cycle_count = 0;
   int items_sent = 0;
   int writes_sent = 0;
   int root_writes = 0;
   int idle_pct = 0;
   int cur_page = 0;

   always #HALF_PERIOD clock = ~clock;

   ept_four_level_walker u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata)
   );

   ept_walk_checker u_walk_check (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_data      (rsp_data),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending       (pending),
      .checked_count (checked_count),
      .fault_count   (fault_count)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d translations outstanding",
                  cycle_count, pending);
         $display("*** FAILED ***");
         $finish;
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Random entry with the given frame; force or clear the read/write/execute bits.
   function automatic logic [51:0] make_entry(logic [39:0] frame, bit valid, bit large_page);
      logic [51:0] e;
      e = 52'(rand64());
      e[51:12] = frame;
      e[7] = large_page;
      if (!valid) e[2:0] = 3'b000;
      else if (e[2:0] == 3'b000) e[2:0] = 3'($urandom_range(7, 1));
      return e;
   endfunction

   task automatic put_item(logic op, logic [47:0] ga, logic [11:0] widx, logic [51:0] wdata);
      req_type item;
      item.operation = op;
      item.guest_addr = ga;
      item.table_word_index = widx;
      item.table_word_data = wdata;
      while ($urandom_range(99, 0) < idle_pct) @(negedge clock) start <= 1'b0;
      @(negedge clock);
      start <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (busy) @(posedge clock);
      items_sent++;
      if (op == OP_WRITE) writes_sent++;
   endtask

   task automatic write_word(logic [11:0] widx, logic [51:0] wdata);
      put_item(OP_WRITE, 48'(rand64()), widx, wdata);
   endtask

   task automatic translate(logic [47:0] ga);
      put_item(OP_XLATE, ga, 12'(rand64()), 52'(rand64()));
   endtask

   // Drop start, let all translations come back, then give the block time to settle.
   task automatic wait_idle();
      @(negedge clock) start <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic set_root(logic [51:0] value);
      wait_idle();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock) csr_valid <= 1'b0;
      root_writes++;
      cur_page = (value[51:12] < TABLE_PAGES) ? int'(value[51:12]) : 0;
   endtask

   // Lay down one walk path for a random address, sometimes broken, then translate along it.
   task automatic build_walk();
      logic [47:0] ga;
      logic [47:0] vary_mask;
      logic [39:0] next_page;
      logic [51:0] e;
      logic [8:0]  idx;
      int          leaf_lvl;
      int          bad_lvl;
      int          kind;
      int          page;
      ga = 48'(rand64());
      kind = $urandom_range(99, 0);
      leaf_lvl = (kind < 40) ? 3 : (kind < 65) ? 2 : 1;
      bad_lvl = ($urandom_range(99, 0) < 20) ? $urandom_range(leaf_lvl, 0) : 4;
      page = cur_page;
      for (int lvl = 0; lvl <= leaf_lvl; lvl++) begin
         idx = ga[47 - 9*lvl -: 9];
         next_page = 40'($urandom_range(TABLE_PAGES - 1, 0));
         if (lvl == leaf_lvl)
            e = make_entry(40'(rand64()), 1'b1,
                           (2'(lvl) == LVL_PT) ? 1'($urandom_range(1, 0)) : 1'b1);
         else
            e = make_entry(next_page, 1'b1,
                           (2'(lvl) == LVL_PML4) ? 1'($urandom_range(1, 0)) : 1'b0);
         if (lvl == bad_lvl) begin
            if (lvl < leaf_lvl && $urandom_range(1, 0))
               e[51:12] = 40'(rand64()) | 40'(TABLE_PAGES);
            else
               e[2:0] = 3'b000;
         end
         write_word(12'(page * TABLE_ENTRIES + int'(idx)), e);
         page = int'(next_page);
      end
      translate(ga);
      vary_mask = (leaf_lvl == 3) ? 48'hFFF : (leaf_lvl == 2) ? 48'h1F_FFFF : 48'h3FFF_FFFF;
      repeat ($urandom_range(2, 0)) translate(ga ^ (48'(rand64()) & vary_mask));
   endtask

   task automatic run_phase(int pct, int count);
      int target;
      idle_pct = pct;
      target = items_sent + count;
      while (items_sent < target) begin
         if ($urandom_range(99, 0) < 80) build_walk();
         else if ($urandom_range(1, 0)) write_word(12'($urandom), 52'(rand64()));
         else translate(48'(rand64()));
      end
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_wdata = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      set_root('0);
      // empty memory: every walk faults at the top level
      translate(48'h0);
      translate('1);
      // 1 GB page through PML4[0] -> PDPT page 1
      write_word(12'd0, {40'd1, 12'h007});
      write_word(12'd512, '1);
      translate(48'h0);
      translate(48'h0000_3FFF_FFFF);
      // 2 MB page, frame from the PD entry
      write_word(12'd513, {40'd2, 12'h003});
      write_word(12'd1024, '1);
      translate(48'h0000_401F_FFFF);
      // 4 KB page; bit 7 in the PT entry is ignored
      write_word(12'd1025, {40'd3, 12'h001});
      write_word(12'd1541, '1);
      translate(48'h0000_4020_5FFF);
      // table named by the PD entry lies outside the memory
      write_word(12'd1026, 52'hF_FFFF_FFFF_F007);
      translate(48'h0000_4040_0000);
      // PDPT entry with no access bits, bit 7 set
      write_word(12'd514, 52'hF_FFFF_FFFF_FFF8);
      translate(48'h0000_8000_0000);
      // bit 7 in a PML4 entry is ignored
      write_word(12'd1, {40'd1, 12'h084});
      translate(48'h0080_1234_5678);
      write_word(12'd4095, '0);
      write_word(12'd4095, '1);
      translate(48'hFFFF_FFFF_F000);

      set_root({40'($urandom_range(TABLE_PAGES - 1, 0)), 12'($urandom)});
      run_phase(34, 260);
      set_root({40'(TABLE_PAGES - 1), 12'hFFF});
      run_phase(51, 230);
      set_root(ROOT_ALL_ONES);
      run_phase(0, 25);
      set_root({40'($urandom_range(TABLE_PAGES - 1, 0)), 12'($urandom)});
      run_phase(0, 110);
      wait_idle();

      $display("Sent %0d items (%0d table writes) under %0d root settings.",
               items_sent, writes_sent, root_writes);
      $display("Checked %0d translations, %0d of them faults; %0d mismatches.",
               checked_count, fault_count, fail_count);
      if (fail_count == 0 && pending == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
